FILE: src/matrix_block_pooling_macros.svh
// Assertion macros shared by the block pooling checker.
`ifndef MATRIX_BLOCK_POOLING_MACROS_SVH
`define MATRIX_BLOCK_POOLING_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MBP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block pooling assertion failed");

// Next-cycle implication, ignored while reset is high.
`define MBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block pooling assertion failed");

// Condition that must hold in the cycle after reset is seen.
`define MBP_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("block pooling reset assertion failed");

`endif

FILE: src/mbp_pkg.sv
// Shared constants, codes and types of the matrix block pooling block.
package mbp_pkg;

  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int MAX_TILE_COLS_DEF = 4096;

  localparam int BS_BITS        = 5;
  localparam int BS_MAX         = 16;
  localparam int MOD_BITS       = 4;
  localparam int DIM_BITS       = 13;
  localparam int DIM_MAX        = 4096;
  localparam int POS_BITS       = 12;
  localparam int CNT_BITS       = 9;
  localparam int TILE_ELEM_BITS = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BLOCK_SIZE  = 3'd0,
    REG_REDUCE_MODE = 3'd1,
    REG_ROW_COUNT   = 3'd2,
    REG_COL_COUNT   = 3'd3,
    REG_SKIP_ZERO   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_AVG     = 2'd0,
    MODE_MAX     = 2'd1,
    MODE_MIN     = 2'd2,
    MODE_MAX_ABS = 2'd3
  } mode_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Where the current element sits in the tile grid.
  typedef struct packed {
    logic                first;
    logic                tile_end;
    logic                mat_end;
    logic [POS_BITS-1:0] tile_row;
    logic [POS_BITS-1:0] tile_col;
  } pos_t;

endpackage

FILE: src/mbp_in_if.sv
// Input channel carrying one matrix element per item.
interface mbp_in_if
  import mbp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

FILE: src/mbp_out_if.sv
// Output channel carrying one finished tile per item.
interface mbp_out_if
  import mbp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [POS_BITS-1:0]           block_row;
  logic [POS_BITS-1:0]           block_col;
  logic signed [SAMPLE_BITS-1:0] block_value;
  logic                          matrix_last;

  modport source (output valid, output block_row, output block_col, output block_value,
                  output matrix_last, input ready);
  modport sink (input valid, input block_row, input block_col, input block_value,
                input matrix_last, output ready);
endinterface

FILE: src/matrix_block_pooling.sv
// Top level of the matrix block pooling block: sequencer, accumulators and result register.
//
// Matrix elements come in raster order and are pooled over square tiles of block_size;
// one accumulator slot per tile column lives in a RAM that is read when an element is
// taken and written back at the end of its update. Sums, compares, negation and the
// division steps run one step per cycle through a single add/subtract unit. An element
// goes through read, sum, maximum, minimum, absolute maximum and write-back before the
// next is taken; the first element of a tile skips maximum, minimum and absolute maximum.
// An element that finishes a tile then passes through an emit step that moves the result
// into the output register, which then holds it while new elements are taken; if that
// register is still full, the sequencer waits for it. In average mode a finished tile
// first goes through the bit-serial division by the element count and its sign correction.
module matrix_block_pooling
  import mbp_pkg::*;
#(
  parameter int MAX_TILE_COLS = MAX_TILE_COLS_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  mbp_in_if.sink                    sample_in,
  mbp_out_if.source                 result_out
);
  localparam int S         = SAMPLE_BITS;
  localparam int SUMW      = S + TILE_ELEM_BITS;
  localparam int ALUW      = SUMW + 1;
  localparam int IDX_BITS  = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int STEP_BITS = $clog2(SUMW);
  localparam int ABS_LSB   = 0;
  localparam int MIN_LSB   = S;
  localparam int MAX_LSB   = 2 * S;
  localparam int CNT_LSB   = 3 * S;
  localparam int SUM_LSB   = CNT_LSB + CNT_BITS;
  localparam int WORDW     = SUM_LSB + SUMW;

  localparam logic signed [S-1:0] VALUE_MIN = {1'b1, {(S-1){1'b0}}};
  localparam logic signed [S-1:0] VALUE_MAX = {1'b0, {(S-1){1'b1}}};

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SUM   = 9'b000000010,
    S_MAX   = 9'b000000100,
    S_MIN   = 9'b000001000,
    S_ABS   = 9'b000010000,
    S_WRITE = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIX   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [BS_BITS-1:0]  block_size;
  mode_t               reduce_mode;
  logic [DIM_BITS-1:0] row_count;
  logic [DIM_BITS-1:0] col_count;
  logic                skip_zero_sum;
  logic [BS_BITS-1:0]  bs_eff;
  logic [DIM_BITS-1:0] rows_eff;
  logic [DIM_BITS-1:0] cols_eff;
  logic                geom_clear;

  // Working registers of the element under update.
  logic signed [S-1:0]    v;
  logic signed [S-1:0]    a_abs;
  logic signed [S-1:0]    abs_sat;
  logic signed [SUMW-1:0] acc_sum;
  logic [CNT_BITS-1:0]    acc_cnt;
  logic signed [S-1:0]    acc_max;
  logic signed [S-1:0]    acc_min;
  logic signed [S-1:0]    acc_abs;
  logic [SUMW-1:0]        dvd;
  logic [CNT_BITS-1:0]    rem;
  logic [CNT_BITS-1:0]    rem_shift;
  logic [STEP_BITS-1:0]   div_step;
  logic                   res_neg;
  logic signed [S-1:0]    res_val;
  logic                   emit;

  // Output register.
  logic                   out_valid;
  logic [POS_BITS-1:0]    out_row;
  logic [POS_BITS-1:0]    out_col;
  logic signed [S-1:0]    out_value;
  logic                   out_last;
  logic                   out_free;

  logic                   accept;
  logic                   advance;
  pos_t                   pos;
  logic [IDX_BITS-1:0]    tile_idx;

  logic                   ram_we;
  logic [WORDW-1:0]       ram_wdata;
  logic [WORDW-1:0]       ram_rdata;

  alu_op_t                alu_op;
  logic signed [ALUW-1:0] alu_a;
  logic signed [ALUW-1:0] alu_b;
  logic signed [ALUW-1:0] alu_y;
  logic                   alu_neg;

  // Effective geometry: zero acts as one, large values clamp.
  always_comb begin
    if (block_size == '0) begin
      bs_eff = BS_BITS'(1);
    end else if (block_size > BS_BITS'(BS_MAX)) begin
      bs_eff = BS_BITS'(BS_MAX);
    end else begin
      bs_eff = block_size;
    end
    if (row_count == '0) begin
      rows_eff = DIM_BITS'(1);
    end else if (row_count > DIM_BITS'(DIM_MAX)) begin
      rows_eff = DIM_BITS'(DIM_MAX);
    end else begin
      rows_eff = row_count;
    end
    if (col_count == '0) begin
      cols_eff = DIM_BITS'(1);
    end else if (col_count > DIM_BITS'(DIM_MAX)) begin
      cols_eff = DIM_BITS'(DIM_MAX);
    end else begin
      cols_eff = col_count;
    end
  end

  assign geom_clear = cfg_we && ((cfg_index == REG_BLOCK_SIZE) ||
                                 (cfg_index == REG_ROW_COUNT) ||
                                 (cfg_index == REG_COL_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= BS_BITS'(1);
      reduce_mode   <= MODE_AVG;
      row_count     <= DIM_BITS'(1);
      col_count     <= DIM_BITS'(1);
      skip_zero_sum <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE:  block_size    <= cfg_data[BS_BITS-1:0];
        REG_REDUCE_MODE: reduce_mode   <= mode_t'(cfg_data[1:0]);
        REG_ROW_COUNT:   row_count     <= cfg_data[DIM_BITS-1:0];
        REG_COL_COUNT:   col_count     <= cfg_data[DIM_BITS-1:0];
        REG_SKIP_ZERO:   skip_zero_sum <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mbp_pos #(
    .MAX_TILE_COLS(MAX_TILE_COLS)
  ) u_pos (
    .clk     (clk),
    .rst     (rst),
    .clear   (geom_clear),
    .advance (advance),
    .bs      (bs_eff),
    .rows    (rows_eff),
    .cols    (cols_eff),
    .pos     (pos),
    .idx     (tile_idx)
  );

  assign ram_wdata = {acc_sum, acc_cnt, acc_max, acc_min, acc_abs};

  mbp_ram #(
    .WIDTH (WORDW),
    .DEPTH (MAX_TILE_COLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tile_idx),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (tile_idx),
    .rdata (ram_rdata)
  );

  mbp_alu #(
    .WIDTH (ALUW)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign alu_neg   = alu_y[ALUW-1];
  assign rem_shift = {rem[CNT_BITS-2:0], dvd[SUMW-1]};

  // Operand selection for the shared unit, at most one operation per state.
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      S_IDLE: begin
        alu_op = ALU_SUB;
        alu_b  = ALUW'(sample_in.sample_value);
      end
      S_SUM: begin
        alu_a = ALUW'(signed'(ram_rdata[SUM_LSB +: SUMW]));
        alu_b = ALUW'(v);
      end
      S_MAX: begin
        alu_op = ALU_SUB;
        alu_a  = ALUW'(acc_max);
        alu_b  = ALUW'(v);
      end
      S_MIN: begin
        alu_op = ALU_SUB;
        alu_a  = ALUW'(v);
        alu_b  = ALUW'(acc_min);
      end
      S_ABS: begin
        alu_op = ALU_SUB;
        alu_a  = ALUW'(acc_abs);
        alu_b  = ALUW'(a_abs);
      end
      S_WRITE: begin
        alu_op = ALU_SUB;
        alu_b  = ALUW'(acc_sum);
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = signed'(ALUW'(rem_shift));
        alu_b  = signed'(ALUW'(acc_cnt));
      end
      S_FIX: begin
        alu_op = ALU_SUB;
        alu_b  = signed'(ALUW'(dvd));
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  // The most negative sample has no positive counterpart and saturates.
  always_comb begin
    if (sample_in.sample_value == VALUE_MIN) begin
      abs_sat = VALUE_MAX;
    end else if (sample_in.sample_value[S-1]) begin
      abs_sat = alu_y[S-1:0];
    end else begin
      abs_sat = sample_in.sample_value;
    end
  end

  assign sample_in.ready = (state == S_IDLE);
  assign accept          = sample_in.valid && sample_in.ready;
  assign out_free        = !out_valid || result_out.ready;
  assign emit            = pos.tile_end && !(skip_zero_sum && (acc_sum == '0));
  assign ram_we          = (state == S_WRITE);
  assign advance         = ((state == S_WRITE) && !emit) || ((state == S_EMIT) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= pos.first ? S_WRITE : S_MAX;
        end
        S_MAX:   state <= S_MIN;
        S_MIN:   state <= S_ABS;
        S_ABS:   state <= S_WRITE;
        S_WRITE: begin
          if (!emit) begin
            state <= S_IDLE;
          end else if (reduce_mode == MODE_AVG) begin
            state <= S_DIV;
          end else begin
            state <= S_EMIT;
          end
        end
        S_DIV: begin
          if (div_step == '0) begin
            state <= S_FIX;
          end
        end
        S_FIX: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          v     <= sample_in.sample_value;
          a_abs <= abs_sat;
        end
      end
      S_SUM: begin
        if (pos.first) begin
          acc_sum <= SUMW'(v);
          acc_cnt <= CNT_BITS'(1);
          acc_max <= v;
          acc_min <= v;
          acc_abs <= a_abs;
        end else begin
          acc_sum <= alu_y[SUMW-1:0];
          acc_cnt <= ram_rdata[CNT_LSB +: CNT_BITS] + CNT_BITS'(1);
          acc_max <= ram_rdata[MAX_LSB +: S];
          acc_min <= ram_rdata[MIN_LSB +: S];
          acc_abs <= ram_rdata[ABS_LSB +: S];
        end
      end
      S_MAX: begin
        if (alu_neg) begin
          acc_max <= v;
        end
      end
      S_MIN: begin
        if (alu_neg) begin
          acc_min <= v;
        end
      end
      S_ABS: begin
        if (alu_neg) begin
          acc_abs <= a_abs;
        end
      end
      S_WRITE: begin
        res_neg  <= acc_sum[SUMW-1];
        dvd      <= acc_sum[SUMW-1] ? alu_y[SUMW-1:0] : acc_sum;
        rem      <= '0;
        div_step <= STEP_BITS'(SUMW - 1);
        case (reduce_mode)
          MODE_AVG:     res_val <= '0;
          MODE_MAX:     res_val <= acc_max;
          MODE_MIN:     res_val <= acc_min;
          MODE_MAX_ABS: res_val <= acc_abs;
        endcase
      end
      S_DIV: begin
        // Restoring division: the quotient bits shift into the dividend register.
        if (alu_neg) begin
          rem <= rem_shift;
          dvd <= {dvd[SUMW-2:0], 1'b0};
        end else begin
          rem <= alu_y[CNT_BITS-1:0];
          dvd <= {dvd[SUMW-2:0], 1'b1};
        end
        div_step <= div_step - STEP_BITS'(1);
      end
      S_FIX: begin
        res_val <= res_neg ? alu_y[S-1:0] : dvd[S-1:0];
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_row   <= pos.tile_row;
      out_col   <= pos.tile_col;
      out_value <= res_val;
      out_last  <= pos.mat_end;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.block_row   = out_row;
  assign result_out.block_col   = out_col;
  assign result_out.block_value = out_value;
  assign result_out.matrix_last = out_last;
endmodule

FILE: src/mbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbp_ram #(
  parameter int  WIDTH     = 8,
  parameter int  DEPTH     = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: src/mbp_alu.sv
// Shared add/subtract unit used for sums, compares, negation and division steps.
module mbp_alu
  import mbp_pkg::*;
#(
  parameter int WIDTH = 33
) (
  input  alu_op_t                 op,
  input  logic signed [WIDTH-1:0] a,
  input  logic signed [WIDTH-1:0] b,
  output logic signed [WIDTH-1:0] y
);
  always_comb begin
    if (op == ALU_SUB) begin
      y = a - b;
    end else begin
      y = a + b;
    end
  end
endmodule

FILE: src/mbp_pos.sv
// Raster position tracker: element position, position inside the tile and tile indexes.
module mbp_pos
  import mbp_pkg::*;
#(
  parameter int  MAX_TILE_COLS = MAX_TILE_COLS_DEF,
  localparam int IDX_BITS      = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                advance,
  input  logic [BS_BITS-1:0]  bs,
  input  logic [DIM_BITS-1:0] rows,
  input  logic [DIM_BITS-1:0] cols,
  output pos_t                pos,
  output logic [IDX_BITS-1:0] idx
);
  logic [POS_BITS-1:0] col;
  logic [POS_BITS-1:0] row;
  logic [MOD_BITS-1:0] col_mod;
  logic [MOD_BITS-1:0] row_mod;
  logic [POS_BITS-1:0] tile_col;
  logic [POS_BITS-1:0] tile_row;
  logic [MOD_BITS-1:0] bs_last;
  logic                last_col;
  logic                last_row;
  logic                col_wrap;
  logic                row_wrap;

  always_comb begin
    bs_last  = MOD_BITS'(bs - BS_BITS'(1));
    last_col = (DIM_BITS'(col) + DIM_BITS'(1)) >= cols;
    last_row = (DIM_BITS'(row) + DIM_BITS'(1)) >= rows;
    col_wrap = (col_mod == bs_last);
    row_wrap = (row_mod == bs_last);

    pos.first    = (col_mod == '0) && (row_mod == '0);
    pos.tile_end = (row_wrap || last_row) && (col_wrap || last_col);
    pos.mat_end  = last_row && last_col;
    pos.tile_row = tile_row;
    pos.tile_col = tile_col;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col      <= '0;
      row      <= '0;
      col_mod  <= '0;
      row_mod  <= '0;
      tile_col <= '0;
      tile_row <= '0;
      idx      <= '0;
    end else if (advance) begin
      if (last_col) begin
        col      <= '0;
        col_mod  <= '0;
        tile_col <= '0;
        idx      <= '0;
        if (last_row) begin
          row      <= '0;
          row_mod  <= '0;
          tile_row <= '0;
        end else begin
          row <= row + POS_BITS'(1);
          if (row_wrap) begin
            row_mod  <= '0;
            tile_row <= tile_row + POS_BITS'(1);
          end else begin
            row_mod <= row_mod + MOD_BITS'(1);
          end
        end
      end else begin
        col <= col + POS_BITS'(1);
        if (col_wrap) begin
          col_mod  <= '0;
          tile_col <= tile_col + POS_BITS'(1);
          // The accumulator slot wraps at the store depth.
          if (idx == IDX_BITS'(MAX_TILE_COLS - 1)) begin
            idx <= '0;
          end else begin
            idx <= idx + IDX_BITS'(1);
          end
        end else begin
          col_mod <= col_mod + MOD_BITS'(1);
        end
      end
    end
  end
endmodule

FILE: src/mbp_checker.sv
// Port-level checks of the block pooling top level, attached by bind.
`include "matrix_block_pooling_macros.svh"

module mbp_checker
  import mbp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [POS_BITS-1:0]    block_row,
  input logic [POS_BITS-1:0]    block_col,
  input logic [SAMPLE_BITS-1:0] block_value,
  input logic                   matrix_last
);
  logic                                in_accept;
  logic [2*POS_BITS+SAMPLE_BITS:0]     out_payload;

  assign in_accept   = in_valid && in_ready;
  assign out_payload = {block_row, block_col, block_value, matrix_last};

  // A result waiting for the sink keeps its payload.
  `MBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
  // Reset empties the output register.
  `MBP_ASSERT_RESET(a_out_reset, !out_valid)
  // The sequencer is busy right after it takes an element.
  `MBP_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ready)
  // A new result never appears the cycle right after an element was taken.
  `MBP_ASSERT_IMPL(a_result_latency, $rose(out_valid), !$past(in_accept))
endmodule

bind matrix_block_pooling mbp_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mbp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample_in.valid),
  .in_ready    (sample_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .block_row   (result_out.block_row),
  .block_col   (result_out.block_col),
  .block_value (result_out.block_value),
  .matrix_last (result_out.matrix_last)
);

FILE: dv/tile_pool_checker.sv
// Checker for the block pooling unit: tracks tiles, predicts each result and compares it.
module tile_pool_checker
  import mbp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  mbp_in_if                         sample_mon,
  mbp_out_if                        result_mon,
  output int                        fail_count,
  output int                        pending,
  output int                        tiles_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW         = SAMPLE_BITS_DEF;
  localparam int TILE_SLOTS = MAX_TILE_COLS_DEF;

  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic signed [SW-1:0] value;
    logic                 last;
  } tile_result_t;

  logic [BS_BITS-1:0]  tile_edge;
  mode_t               pool_mode;
  logic [DIM_BITS-1:0] row_total;
  logic [DIM_BITS-1:0] col_total;
  logic                skip_zero;

  // One set of running accumulators per tile column.
  longint              slot_sum   [TILE_SLOTS];
  logic [CNT_BITS-1:0] slot_count [TILE_SLOTS];
  longint              slot_max   [TILE_SLOTS];
  longint              slot_min   [TILE_SLOTS];
  longint              slot_abs   [TILE_SLOTS];
  int unsigned         row_at;
  int unsigned         col_at;

  tile_result_t expected_tiles[$];

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic pool_sample(input logic signed [SW-1:0] elem);
    int unsigned span, rows, cols, r, c, tcol, slot;
    longint val, mag, lim, pooled;
    bit last_row, last_col, tile_done;
    span = clamp_dim(tile_edge, BS_MAX);
    rows = clamp_dim(row_total, DIM_MAX);
    cols = clamp_dim(col_total, DIM_MAX);
    r    = row_at;
    c    = col_at;
    tcol = c / span;
    slot = tcol % TILE_SLOTS;
    val  = longint'(elem);
    lim  = (longint'(1) << (SW - 1)) - 1;
    mag  = (val < 0) ? -val : val;
    // The most negative element has no positive counterpart; it saturates.
    if (mag > lim) mag = lim;

    if ((r % span) == 0 && (c % span) == 0) begin
      slot_sum[slot]   = val;
      slot_count[slot] = CNT_BITS'(1);
      slot_max[slot]   = val;
      slot_min[slot]   = val;
      slot_abs[slot]   = mag;
    end else begin
      slot_sum[slot]   += val;
      slot_count[slot] += 1'b1;
      if (val > slot_max[slot]) slot_max[slot] = val;
      if (val < slot_min[slot]) slot_min[slot] = val;
      if (mag > slot_abs[slot]) slot_abs[slot] = mag;
    end

    last_row  = (r + 1 >= rows);
    last_col  = (c + 1 >= cols);
    tile_done = ((r % span) == span - 1 || last_row) && ((c % span) == span - 1 || last_col);

    if (tile_done && !(skip_zero && slot_sum[slot] == 0)) begin
      case (pool_mode)
        MODE_AVG: begin
          pooled = (slot_count[slot] != 0) ? slot_sum[slot] / longint'(slot_count[slot]) : 0;
        end
        MODE_MAX: pooled = slot_max[slot];
        MODE_MIN: pooled = slot_min[slot];
        default:  pooled = slot_abs[slot];
      endcase
      expected_tiles.push_back('{row: POS_BITS'(r / span), col: POS_BITS'(tcol),
                                 value: SW'(pooled), last: last_row && last_col});
    end

    if (last_col) begin
      col_at = 0;
      row_at = last_row ? 0 : (r + 1) % DIM_MAX;
    end else begin
      col_at = (c + 1) % DIM_MAX;
    end
  endtask

  always @(posedge clk) begin
    tile_result_t want;
    if (rst) begin
      tile_edge     = BS_BITS'(1);
      pool_mode     = MODE_AVG;
      row_total     = DIM_BITS'(1);
      col_total     = DIM_BITS'(1);
      skip_zero     = 1'b0;
      row_at        = 0;
      col_at        = 0;
      fail_count    = 0;
      tiles_checked = 0;
      expected_tiles.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_SIZE: begin
            tile_edge = cfg_data[BS_BITS-1:0];
            row_at    = 0;
            col_at    = 0;
          end
          REG_REDUCE_MODE: pool_mode = mode_t'(cfg_data[1:0]);
          REG_ROW_COUNT: begin
            row_total = cfg_data;
            row_at    = 0;
            col_at    = 0;
          end
          REG_COL_COUNT: begin
            col_total = cfg_data;
            row_at    = 0;
            col_at    = 0;
          end
          REG_SKIP_ZERO: skip_zero = cfg_data[0];
          default: ;
        endcase
      end

      if (sample_mon.valid && sample_mon.ready) pool_sample(sample_mon.sample_value);

      if (result_mon.valid && result_mon.ready) begin
        if (expected_tiles.size() == 0) begin
          $error("unexpected tile result: block_row %0d block_col %0d block_value %0d",
                 result_mon.block_row, result_mon.block_col, $signed(result_mon.block_value));
          fail_count++;
        end else begin
          want = expected_tiles.pop_front();
          tiles_checked++;
          if (result_mon.block_row !== want.row) begin
            $error("block_row: expected %0d, got %0d", want.row, result_mon.block_row);
            fail_count++;
          end
          if (result_mon.block_col !== want.col) begin
            $error("block_col: expected %0d, got %0d", want.col, result_mon.block_col);
            fail_count++;
          end
          if (result_mon.block_value !== want.value) begin
            $error("block_value: expected %0d, got %0d", $signed(want.value),
                   $signed(result_mon.block_value));
            fail_count++;
          end
          if (result_mon.matrix_last !== want.last) begin
            $error("matrix_last: expected %0d, got %0d", want.last, result_mon.matrix_last);
            fail_count++;
          end
        end
      end
    end
    pending = expected_tiles.size();
  end

endmodule

FILE: dv/tb_top.sv
// Top of the block pooling testbench: clock, reset, register writes, element stream and verdict.
module tb_top
  import mbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = REG_SKIP_ZERO + 1'b1;
  // Elements sent before the closing phases, and elements in each closing phase.
  localparam int LOOP_ITEMS  = 650;
  localparam int FINAL_ITEMS = 48;

  typedef enum int {
    FILL_RANDOM,
    FILL_SPARSE,
    FILL_SMALL,
    FILL_EDGES,
    FILL_MOST_NEG,
    FILL_MOST_POS
  } fill_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        fail_count;
  int                        pending;
  int                        tiles_checked;

  // Register values as last written, to size whole matrices.
  logic [BS_BITS-1:0]  set_span = BS_BITS'(1);
  logic [DIM_BITS-1:0] set_rows = DIM_BITS'(1);
  logic [DIM_BITS-1:0] set_cols = DIM_BITS'(1);

  int samples_sent   = 0;
  int settings_used  = 0;
  bit sender_idle    = 1'b1;
  bit sink_idle      = 1'b1;
  bit quiet          = 1'b0;

  mbp_in_if  sample_ch ();
  mbp_out_if result_ch ();

  matrix_block_pooling u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_ch.sink),
    .result_out (result_ch.source)
  );

  tile_pool_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_mon    (sample_ch),
    .result_mon    (result_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .tiles_checked (tiles_checked)
  );

  always #2 clk = ~clk;

  function automatic int unsigned eff_dim(input logic [DIM_BITS-1:0] v);
    if (v == 0) return 1;
    return (v > DIM_MAX) ? DIM_MAX : v;
  endfunction

  // Narrow registers sometimes get junk in the unused upper data bits.
  function automatic logic [CFG_DATA_BITS-1:0] pad_upper(input int unsigned v, input int width);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_BITS'($urandom) : '0;
    return ((junk >> width) << width) | CFG_DATA_BITS'(v);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample(input fill_t fill);
    logic signed [SW-1:0] v;
    v = SW'($urandom);
    case (fill)
      FILL_SPARSE: if ($urandom_range(0, 9) < 7) v = '0;
      FILL_SMALL:  v = SW'($urandom_range(0, 6)) - SW'(3);
      FILL_EDGES: begin
        case ($urandom_range(0, 5))
          0: v = SAMPLE_MIN;
          1: v = SAMPLE_MAX;
          2: v = '0;
          3: v = '1;
          4: v = SW'(1);
          default: ;
        endcase
      end
      FILL_MOST_NEG: v = SAMPLE_MIN;
      FILL_MOST_POS: v = SAMPLE_MAX;
      default: ;
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLOCK_SIZE: set_span = data[BS_BITS-1:0];
      REG_ROW_COUNT:  set_rows = data;
      REG_COL_COUNT:  set_cols = data;
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic signed [SW-1:0] v);
    if (sender_idle && !quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_value <= v;
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
  endtask

  // Stops the stream and waits until every tile is out and the divider has gone quiet.
  task automatic drain_results();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (48) @(negedge clk);
    settings_used++;
  endtask

  task automatic run_phase(input int count, input fill_t fill);
    for (int k = 0; k < count; k++) send_sample(pick_sample(fill));
    drain_results();
  endtask

  // Result side: ready drops at random while sink_idle is set and the run is not quiet.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_idle && !quiet && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #10ms;
    $display("timeout waiting for the block");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int    k, span_raw, row_raw, col_raw, total, count;
    fill_t fill;
    clk                    = 1'b0;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.sample_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single-element tiles at both extremes, average then absolute maximum.
    write_reg(REG_SKIP_ZERO, CFG_DATA_BITS'(0));
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_AVG));
    write_reg(REG_BLOCK_SIZE, CFG_DATA_BITS'(1));
    write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(1));
    write_reg(REG_COL_COUNT, CFG_DATA_BITS'(1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    drain_results();
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_MAX_ABS));
    send_sample(SAMPLE_MIN);
    send_sample('1);
    drain_results();

    // One 2x2 tile, maximum then minimum.
    write_reg(REG_BLOCK_SIZE, CFG_DATA_BITS'(2));
    write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(2));
    write_reg(REG_COL_COUNT, CFG_DATA_BITS'(2));
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_MAX));
    send_sample(SW'(3));
    send_sample(-SW'(7));
    send_sample(SAMPLE_MAX);
    send_sample('0);
    drain_results();
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_MIN));
    send_sample(SAMPLE_MIN);
    send_sample(SW'(5));
    send_sample(SW'(5));
    send_sample(SW'(5));
    drain_results();

    // A negative sum that does not divide evenly, then a partial right tile.
    write_reg(REG_COL_COUNT, CFG_DATA_BITS'(3));
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_AVG));
    send_sample(-SW'(7));
    send_sample(SW'(2));
    send_sample(SW'(5));
    send_sample('0);
    send_sample('1);
    send_sample(SW'(4));
    drain_results();

    // A tile of nonzero elements that cancel is suppressed.
    write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(1));
    write_reg(REG_COL_COUNT, CFG_DATA_BITS'(2));
    write_reg(REG_SKIP_ZERO, CFG_DATA_BITS'(1));
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_MAX));
    send_sample(SW'(5));
    send_sample(-SW'(5));
    drain_results();

    // Largest full tile of the most negative element: the sum reaches its lower bound.
    write_reg(REG_SKIP_ZERO, CFG_DATA_BITS'(0));
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_AVG));
    write_reg(REG_BLOCK_SIZE, CFG_DATA_BITS'(BS_MAX));
    write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(16));
    write_reg(REG_COL_COUNT, CFG_DATA_BITS'(16));
    run_phase(256, FILL_MOST_NEG);

    while (samples_sent < LOOP_ITEMS) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      write_reg(REG_REDUCE_MODE, pad_upper($urandom_range(0, 3), 2));
      if ($urandom_range(0, 1) == 0) write_reg(REG_SKIP_ZERO, pad_upper($urandom_range(0, 1), 1));
      if ($urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, 19);
        if (k == 0)       span_raw = 0;
        else if (k == 1)  span_raw = $urandom_range(BS_MAX + 1, 31);
        else if (k == 2)  span_raw = BS_MAX;
        else if (k < 14)  span_raw = $urandom_range(1, 4);
        else              span_raw = $urandom_range(5, 8);
        k = $urandom_range(0, 19);
        if (k == 0)       row_raw = 0;
        else if (k == 1)  row_raw = $urandom_range(DIM_MAX + 1, 8191);
        else if (k < 4)   row_raw = $urandom_range(13, 24);
        else              row_raw = $urandom_range(1, 12);
        k = $urandom_range(0, 19);
        if (k == 0)       col_raw = 0;
        else if (k == 1)  col_raw = $urandom_range(DIM_MAX + 1, 8191);
        else if (k < 4)   col_raw = $urandom_range(13, 24);
        else              col_raw = $urandom_range(1, 12);
        write_reg(REG_BLOCK_SIZE, pad_upper(span_raw, BS_BITS));
        write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(row_raw));
        write_reg(REG_COL_COUNT, CFG_DATA_BITS'(col_raw));
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_SPARE_FIRST + CFG_INDEX_BITS'($urandom_range(0, 2)),
                  CFG_DATA_BITS'($urandom));
      end

      fill = fill_t'($urandom_range(0, 3));
      if ($urandom_range(0, 14) == 0) fill = ($urandom_range(0, 1) != 0) ? FILL_MOST_NEG
                                                                         : FILL_MOST_POS;
      // Whole matrices, sometimes two in a row; otherwise cut off mid-matrix.
      total = eff_dim(set_rows) * eff_dim(set_cols);
      k     = $urandom_range(0, 9);
      if (total > 600)  count = $urandom_range(1, 40);
      else if (k < 5)   count = total * $urandom_range(1, 2);
      else              count = $urandom_range(1, total);
      if (count > LOOP_ITEMS - samples_sent) count = LOOP_ITEMS - samples_sent;
      run_phase(count, fill);
    end

    // Full height from a clamped row count, then full width, streamed without idling.
    quiet       = 1'b1;
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    write_reg(REG_BLOCK_SIZE, CFG_DATA_BITS'(1));
    write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(8191));
    write_reg(REG_COL_COUNT, CFG_DATA_BITS'(1));
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_MAX));
    write_reg(REG_SKIP_ZERO, CFG_DATA_BITS'(0));
    run_phase(FINAL_ITEMS, FILL_RANDOM);
    write_reg(REG_ROW_COUNT, CFG_DATA_BITS'(0));
    write_reg(REG_COL_COUNT, CFG_DATA_BITS'(DIM_MAX));
    write_reg(REG_REDUCE_MODE, CFG_DATA_BITS'(MODE_MIN));
    write_reg(REG_SKIP_ZERO, CFG_DATA_BITS'(1));
    run_phase(FINAL_ITEMS, FILL_SPARSE);

    $display("Streamed %0d elements through %0d register settings: all reduce modes,",
             samples_sent, settings_used);
    $display("tile edges 1 to 16, partial tiles, zero-sum skipping; %0d tiles compared.",
             tiles_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
